>>> rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

>>> rtl/ecpa_pkg.sv
package ecpa_pkg;
  localparam int FIELD_BITS = 32;
  localparam int FB = FIELD_BITS;
  localparam int CNT_W = $clog2(FB + 1);

  // datapath register file addresses
  typedef enum logic [3:0] {
    R_X1 = 4'd0, R_Y1 = 4'd1, R_X2 = 4'd2, R_Y2 = 4'd3,
    R_A = 4'd4, R_B = 4'd5, R_C = 4'd6, R_T0 = 4'd7,
    R_T1 = 4'd8, R_T2 = 4'd9, R_LAM = 4'd10, R_X3 = 4'd11,
    R_ONE = 4'd12, R_ZERO = 4'd13, R_TWO = 4'd14, R_THREE = 4'd15
  } reg_id_t;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0, OP_ADD = 3'd1, OP_SUB = 3'd2, OP_MUL = 3'd3,
    OP_RED = 3'd4, OP_MOV = 3'd5
  } op_t;

  typedef struct packed {
    logic    go;
    op_t     op;
    reg_id_t src_a;
    reg_id_t src_b;
    reg_id_t dst;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic eq;
    logic a_zero;
  } dp_stat_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD1 = 2'd1;
  localparam logic [1:0] ST_BAD2 = 2'd2;
endpackage

>>> rtl/ecpa_datapath.sv
// register file, modular add, sub and move, and a shared bit-serial unit for mul and reduce
module ecpa_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  ecpa_pkg::dp_cmd_t  cmd,
  input  logic [ecpa_pkg::FB-1:0] p,
  input  logic               load,
  input  logic [ecpa_pkg::FB-1:0] ld_x1, ld_y1, ld_x2, ld_y2, ld_a, ld_b, ld_c,
  output ecpa_pkg::dp_stat_t stat,
  output logic [ecpa_pkg::FB-1:0] rd_x,
  output logic [ecpa_pkg::FB-1:0] rd_y
);
  import ecpa_pkg::*;
  `include "assert_macros.svh"

  logic [FB-1:0] rf_r [0:11];
  logic [FB-1:0] opa_r, opb_r, acc_r;
  logic [FB-1:0] opa, opb;
  logic [CNT_W-1:0] cnt_r;
  logic busy_r;
  op_t op_r;
  reg_id_t dst_r;
  logic [FB:0] dbl, dsum, rsh;
  logic [FB-1:0] acc2, accn;

  function automatic logic [FB-1:0] rd(input reg_id_t id, input logic [FB-1:0] pp);
    logic [FB-1:0] v;
    case (id)
      R_ONE:   v = FB'(1);
      R_ZERO:  v = '0;
      R_TWO:   v = FB'(2);
      R_THREE: v = FB'(3) >= pp ? '0 : FB'(3);
      default: v = rf_r[id];
    endcase
    return v;
  endfunction

  assign opa = rd(cmd.src_a, p);
  assign opb = rd(cmd.src_b, p);

  // one bit per cycle, msb first
  always_comb begin
    dbl  = {1'b0, acc_r} + {1'b0, acc_r};
    acc2 = (dbl >= {1'b0, p}) ? FB'(dbl - {1'b0, p}) : dbl[FB-1:0];
    dsum = {1'b0, acc2} + {1'b0, opa_r};
    accn = opb_r[FB-1] ? ((dsum >= {1'b0, p}) ? FB'(dsum - {1'b0, p}) : dsum[FB-1:0]) : acc2;
    // restoring remainder step for reduction: shift in one bit of opa
    rsh  = {acc_r, opa_r[FB-1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (op_r == OP_MUL) begin
        acc_r <= accn;
        opb_r <= opb_r << 1;
      end else begin
        acc_r <= (rsh >= {1'b0, p}) ? FB'(rsh - {1'b0, p}) : rsh[FB-1:0];
        opa_r <= opa_r << 1;
      end
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        rf_r[dst_r] <= (op_r == OP_MUL) ? accn :
          ((rsh >= {1'b0, p}) ? FB'(rsh - {1'b0, p}) : rsh[FB-1:0]);
      end
      cnt_r <= cnt_r - CNT_W'(1);
    end else if (cmd.go) begin
      dst_r <= cmd.dst;
      op_r  <= cmd.op;
      case (cmd.op)
        OP_ADD: rf_r[cmd.dst] <= (opa >= p - opb) ? opa - (p - opb) : opa + opb;
        OP_SUB: rf_r[cmd.dst] <= (opa >= opb) ? opa - opb : opa + (p - opb);
        OP_MOV: rf_r[cmd.dst] <= opa;
        OP_MUL, OP_RED: begin
          opa_r  <= opa;
          opb_r  <= opb;
          acc_r  <= '0;
          busy_r <= 1'b1;
          cnt_r  <= CNT_W'(FB);
        end
        default: ;
      endcase
    end else if (load) begin
      rf_r[R_X1] <= ld_x1; rf_r[R_Y1] <= ld_y1;
      rf_r[R_X2] <= ld_x2; rf_r[R_Y2] <= ld_y2;
      rf_r[R_A]  <= ld_a;  rf_r[R_B]  <= ld_b;  rf_r[R_C] <= ld_c;
    end
  end

  assign stat.busy   = busy_r;
  assign stat.eq     = (opa == opb);
  assign stat.a_zero = (opa == '0);
  assign rd_x = rf_r[R_X3];
  assign rd_y = rf_r[R_T2];

  `ASSERT_IMPL(a_cnt_idle, clk, rst_n, busy_r || cnt_r == '0)
  `ASSERT_NEXT(a_busy_cnt, clk, rst_n, busy_r && cnt_r > CNT_W'(1), busy_r)
  `ASSERT_IMPL(a_cnt_range, clk, rst_n, cnt_r <= CNT_W'(FB))
endmodule

>>> rtl/ecpa_ctrl.sv
// sequencer: reduce inputs, check curve, pick case, invert, finish
module ecpa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               inf1,
  input  logic               inf2,
  input  logic [ecpa_pkg::FB-1:0] e,
  input  ecpa_pkg::dp_stat_t stat,
  output ecpa_pkg::dp_cmd_t  cmd,
  output logic               done,
  output logic [1:0]         res_status,
  output logic               res_z
);
  import ecpa_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_RUN = 4'b0010, S_WAIT = 4'b0100, S_DONE = 4'b1000
  } state_t;

  // micro-op program index
  typedef enum logic [5:0] {
    P_RX1, P_RY1, P_RX2, P_RY2, P_RA, P_RB, P_RC,
    P_CK1, P_CK2, P_CK3, P_CK4, P_CK5, P_CK6, P_CK7, P_CKC,
    P_SEL, P_D1, P_D2, P_D3, P_D4, P_D5, P_D6, P_D7,
    P_C1, P_C2, P_INI, P_SQ, P_ML,
    P_L1, P_X1, P_X2, P_X3, P_X4, P_Y1, P_Y2, P_Y3, P_Y4, P_Y5, P_Y6,
    P_PX, P_PY,
    P_END
  } pc_t;

  state_t state_r, state_nxt;
  pc_t pc_r, pc_nxt;
  logic chk2_r, chk2_nxt;
  logic [CNT_W-1:0] bit_r, bit_nxt;
  logic [1:0] st_r, st_nxt;
  logic z_r, z_nxt, sel_r, sel_nxt;
  logic issue;
  dp_cmd_t c;
  logic [FB-1:0] e_sh;

  function automatic pc_t pc_pkg_next(input pc_t x);
    return pc_t'(x + 6'd1);
  endfunction

  assign e_sh = e >> (bit_r - CNT_W'(1));

  // instruction for current pc; point under check selects x1/y1 or x2/y2
  always_comb begin
    reg_id_t px, py, qx, qy;
    px = chk2_r ? R_X2 : R_X1;
    py = chk2_r ? R_Y2 : R_Y1;
    // passthrough copies the affine input into the result registers
    qx = sel_r ? R_X2 : R_X1;
    qy = sel_r ? R_Y2 : R_Y1;
    c = '{go: 1'b1, op: OP_NONE, src_a: R_ZERO, src_b: R_ZERO, dst: R_T0};
    case (pc_r)
      P_RX1: c = '{1'b1, OP_RED, R_X1, R_ZERO, R_X1};
      P_RY1: c = '{1'b1, OP_RED, R_Y1, R_ZERO, R_Y1};
      P_RX2: c = '{1'b1, OP_RED, R_X2, R_ZERO, R_X2};
      P_RY2: c = '{1'b1, OP_RED, R_Y2, R_ZERO, R_Y2};
      P_RA:  c = '{1'b1, OP_RED, R_A, R_ZERO, R_A};
      P_RB:  c = '{1'b1, OP_RED, R_B, R_ZERO, R_B};
      P_RC:  c = '{1'b1, OP_RED, R_C, R_ZERO, R_C};
      P_CK1: c = '{1'b1, OP_ADD, px, R_A, R_T0};
      P_CK2: c = '{1'b1, OP_MUL, R_T0, px, R_T0};
      P_CK3: c = '{1'b1, OP_ADD, R_T0, R_B, R_T0};
      P_CK4: c = '{1'b1, OP_MUL, R_T0, px, R_T0};
      P_CK5: c = '{1'b1, OP_ADD, R_T0, R_C, R_T0};
      P_CK6: c = '{1'b1, OP_MUL, py, py, R_T1};
      P_CK7: c = '{1'b0, OP_NONE, R_T0, R_T1, R_T0};
      P_CKC: c = '{1'b0, OP_NONE, R_X1, R_X2, R_T0};
      P_SEL: c = '{1'b0, OP_NONE, R_Y1, R_Y2, R_T0};
      P_D1:  c = '{1'b1, OP_MUL, R_X1, R_X1, R_T0};
      P_D2:  c = '{1'b1, OP_MUL, R_T0, R_THREE, R_T0};
      P_D3:  c = '{1'b1, OP_MUL, R_A, R_X1, R_T1};
      P_D4:  c = '{1'b1, OP_ADD, R_T1, R_T1, R_T1};
      P_D5:  c = '{1'b1, OP_ADD, R_T0, R_T1, R_T0};
      P_D6:  c = '{1'b1, OP_ADD, R_T0, R_B, R_T0};
      P_D7:  c = '{1'b1, OP_ADD, R_Y1, R_Y1, R_T1};
      P_C1:  c = '{1'b1, OP_SUB, R_Y2, R_Y1, R_T0};
      P_C2:  c = '{1'b1, OP_SUB, R_X2, R_X1, R_T1};
      P_INI: c = '{1'b1, OP_MOV, R_ONE, R_ZERO, R_T2};
      P_SQ:  c = '{1'b1, OP_MUL, R_T2, R_T2, R_T2};
      P_ML:  c = '{1'b1, OP_MUL, R_T2, R_T1, R_T2};
      P_L1:  c = '{1'b1, OP_MUL, R_T0, R_T2, R_LAM};
      P_X1:  c = '{1'b1, OP_MUL, R_LAM, R_LAM, R_T0};
      P_X2:  c = '{1'b1, OP_SUB, R_T0, R_A, R_T0};
      P_X3:  c = '{1'b1, OP_SUB, R_T0, R_X1, R_T0};
      P_X4:  c = '{1'b1, OP_SUB, R_T0, R_X2, R_X3};
      P_Y1:  c = '{1'b1, OP_MUL, R_LAM, R_X1, R_T0};
      P_Y2:  c = '{1'b1, OP_SUB, R_Y1, R_T0, R_T1};
      P_Y3:  c = '{1'b1, OP_MUL, R_LAM, R_X3, R_T0};
      P_Y4:  c = '{1'b1, OP_ADD, R_T0, R_T1, R_T0};
      P_Y5:  c = '{1'b1, OP_SUB, R_ZERO, R_T0, R_T2};
      P_Y6:  c = '{1'b0, OP_NONE, R_ZERO, R_ZERO, R_T0};
      P_PX:  c = '{1'b1, OP_MOV, qx, R_ZERO, R_X3};
      P_PY:  c = '{1'b1, OP_MOV, qy, R_ZERO, R_T2};
      default: c = '{1'b0, OP_NONE, R_ZERO, R_ZERO, R_T0};
    endcase
  end

  assign issue = (state_r == S_RUN) && c.go;
  always_comb begin
    cmd = c;
    cmd.go = issue;
  end

  always_comb begin
    state_nxt = state_r; pc_nxt = pc_r; chk2_nxt = chk2_r; bit_nxt = bit_r;
    st_nxt = st_r; z_nxt = z_r; sel_nxt = sel_r;
    case (state_r)
      S_IDLE: if (start) begin
        state_nxt = S_RUN; pc_nxt = P_RX1; chk2_nxt = 1'b0;
        st_nxt = ST_OK; z_nxt = 1'b0; sel_nxt = 1'b0;
      end
      S_RUN: begin
        if (c.go) state_nxt = S_WAIT;
        case (pc_r)
          // a first point at infinity skips its own check
          P_RC: pc_nxt = inf1 ? P_CKC : P_CK1;
          P_CK7: begin
            if (!stat.eq) begin
              st_nxt = chk2_r ? ST_BAD2 : ST_BAD1; state_nxt = S_DONE;
            end else pc_nxt = P_CKC;
          end
          P_CKC: begin
            // decide whether the other point still needs a check
            if (!chk2_r && !inf2) begin
              chk2_nxt = 1'b1; pc_nxt = P_CK1;
            end else if (inf1 && inf2) state_nxt = S_DONE;
            else if (inf1) begin
              z_nxt = 1'b1; sel_nxt = 1'b1; pc_nxt = P_PX;
            end else if (inf2) begin
              z_nxt = 1'b1; sel_nxt = 1'b0; pc_nxt = P_PX;
            end else if (stat.eq) pc_nxt = P_SEL;
            else pc_nxt = P_C1;
          end
          P_SEL: begin
            if (!stat.eq || stat.a_zero) state_nxt = S_DONE;
            else pc_nxt = P_D1;
          end
          P_D7: pc_nxt = P_INI;
          P_C2: pc_nxt = P_INI;
          P_INI: begin
            pc_nxt = P_SQ; bit_nxt = CNT_W'(FB);
          end
          P_SQ: pc_nxt = e_sh[0] ? P_ML : P_SQ;
          P_ML: pc_nxt = P_SQ;
          P_PY: pc_nxt = P_Y6;
          P_Y6: begin
            z_nxt = 1'b1; sel_nxt = 1'b0; state_nxt = S_DONE;
          end
          default: pc_nxt = pc_pkg_next(pc_r);
        endcase
        if (pc_r == P_SQ || pc_r == P_ML) begin
          if ((pc_r == P_SQ && !e_sh[0]) || pc_r == P_ML) begin
            bit_nxt = bit_r - CNT_W'(1);
            if (bit_r == CNT_W'(1)) pc_nxt = P_L1;
          end
        end
      end
      S_WAIT: if (!stat.busy) state_nxt = S_RUN;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; pc_r <= P_RX1; chk2_r <= 1'b0; bit_r <= '0;
      st_r <= ST_OK; z_r <= 1'b0; sel_r <= 1'b0;
    end else begin
      state_r <= state_nxt; pc_r <= pc_nxt; chk2_r <= chk2_nxt; bit_r <= bit_nxt;
      st_r <= st_nxt; z_r <= z_nxt; sel_r <= sel_nxt;
    end
  end

  assign done = (state_r == S_DONE);
  assign res_status = st_r;
  assign res_z = z_r;

  `ASSERT_IMPL(a_onehot, clk, rst_n, $onehot(state_r))
  `ASSERT_NEXT(a_done_idle, clk, rst_n, state_r == S_DONE, state_r == S_IDLE)
  `ASSERT_IMPL(a_err_noz, clk, rst_n, !(done && st_r != ST_OK && z_r))
  `ASSERT_IMPL(a_issue_free, clk, rst_n, !(issue && stat.busy))
endmodule

>>> rtl/ec_point_add_prime_field.sv
// Affine point addition on y^2 = x^3 + a x^2 + b x + c over GF(p), one transaction at a
// time. A transaction is accepted only while the block is idle and no result is waiting;
// its result is held in an output register until taken. Multiplies and reductions run on
// the single bit-serial modular unit; adds, subtracts and moves do not. A full addition
// runs seven input reductions, one curve check per affine point (three multiplies each),
// the inverse u^(p-2) with FIELD_BITS squarings and one multiply per set bit of p-2, then
// four more multiplies (seven when doubling); infinity, vertical-line and error cases
// finish without the inversion.
// Status 1 or 2 flags an off-curve first or second point and returns infinity.
// Configuration (modulus, coef_a, coef_b, coef_c) may be written only while idle.
module ec_point_add_prime_field (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // px1[31:0], py1[63:32], pz1[64], px2[96:65], py2[128:97], pz2[129], zero pad
  input  logic [135:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // sum_x[31:0], sum_y[63:32], sum_z[64], status[66:65], zero pad
  output logic [71:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import ecpa_pkg::*;

  typedef enum logic [1:0] {
    CFG_MODULUS = 2'd0, CFG_COEF_A = 2'd1, CFG_COEF_B = 2'd2, CFG_COEF_C = 2'd3
  } cfg_idx_t;

  logic [31:0] mod_r, ca_r, cb_r, cc_r;
  logic [FB-1:0] p_eff, e;
  logic busy_r, inf1_r, inf2_r;
  logic ovalid_r;
  logic [71:0] odata_r;
  logic start;
  dp_cmd_t cmd;
  dp_stat_t stat;
  logic done, res_z;
  logic [1:0] res_status;
  logic [FB-1:0] rd_x, rd_y, fx, fy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= 32'd3; ca_r <= '0; cb_r <= '0; cc_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MODULUS: mod_r <= cfg_wdata;
        CFG_COEF_A:  ca_r  <= cfg_wdata;
        CFG_COEF_B:  cb_r  <= cfg_wdata;
        CFG_COEF_C:  cc_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // modulus below 3 is treated as 3
  assign p_eff = (mod_r < 32'd3) ? FB'(3) : mod_r;
  assign e = p_eff - FB'(2);

  assign in_tready = !busy_r && !ovalid_r;
  assign start = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      inf1_r <= !in_tdata[64];
      inf2_r <= !in_tdata[129];
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  ecpa_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .p(p_eff), .load(start),
    .ld_x1(in_tdata[31:0]), .ld_y1(in_tdata[63:32]),
    .ld_x2(in_tdata[96:65]), .ld_y2(in_tdata[128:97]),
    .ld_a(ca_r), .ld_b(cb_r), .ld_c(cc_r),
    .stat(stat), .rd_x(rd_x), .rd_y(rd_y)
  );

  ecpa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .inf1(inf1_r), .inf2(inf2_r),
    .e(e), .stat(stat), .cmd(cmd), .done(done), .res_status(res_status),
    .res_z(res_z)
  );

  // affine results, passthrough included, sit in the x3 and t2 registers
  assign fx = res_z ? rd_x : '0;
  assign fy = res_z ? rd_y : FB'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (done) begin
      ovalid_r <= 1'b1;
      odata_r  <= {5'd0, res_status, res_z, fy, fx};
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
endmodule

>>> tb/ec_point_add_prime_field_tb.sv
`timescale 1ns / 1ps

module ec_point_add_prime_field_tb;
  import ecpa_pkg::*;

  // configuration register indexes
  localparam logic [1:0] CFG_MODULUS = 2'd0;
  localparam logic [1:0] CFG_COEF_A  = 2'd1;
  localparam logic [1:0] CFG_COEF_B  = 2'd2;
  localparam logic [1:0] CFG_COEF_C  = 2'd3;

  typedef struct packed {
    logic [31:0] px1;
    logic [31:0] py1;
    logic        pz1;
    logic [31:0] px2;
    logic [31:0] py2;
    logic        pz2;
  } pt_pair_t;

  typedef struct packed {
    logic [31:0] sum_x;
    logic [31:0] sum_y;
    logic        sum_z;
    logic [1:0]  status;
  } pt_sum_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  // px1, py1, pz1, px2, py2, pz2 from bit 0 up, zero pad
  logic [135:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  // sum_x, sum_y, sum_z, status from bit 0 up, zero pad
  logic [71:0]  out_tdata;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [31:0]  cfg_wdata;

  ec_point_add_prime_field dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // shadow copy of the configuration
  logic [63:0] fld_p, crv_a, crv_b, crv_c;

  pt_pair_t pending_pairs[$];
  pt_sum_t  expected_sums[$];
  int       n_errors = 0;
  int       n_sent = 0;
  int       n_checked = 0;
  int       n_doublings = 0;
  int       n_chords = 0;
  int       n_off_curve = 0;
  bit       quiet_tail;   // no idling near the end
  bit       rx_hold;      // long receiver hold-off
  bit       tx_pause;     // sender waits for drain

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- field arithmetic ----------------
  function automatic logic [63:0] fadd(logic [63:0] u, logic [63:0] v, logic [63:0] p);
    return (u >= p - v) ? u - (p - v) : u + v;
  endfunction

  function automatic logic [63:0] fsub(logic [63:0] u, logic [63:0] v, logic [63:0] p);
    return (u >= v) ? u - v : u + (p - v);
  endfunction

  function automatic logic [63:0] fmul(logic [63:0] u, logic [63:0] v, logic [63:0] p);
    logic [63:0] r;
    r = 0;
    for (int i = FIELD_BITS - 1; i >= 0; i--) begin
      r = fadd(r, r, p);
      if (v[i]) r = fadd(r, u, p);
    end
    return r;
  endfunction

  // inverse by fermat power, so a zero gives zero
  function automatic logic [63:0] finv(logic [63:0] u, logic [63:0] p);
    logic [63:0] e, r;
    e = p - 2;
    r = 1 % p;
    for (int i = FIELD_BITS - 1; i >= 0; i--) begin
      r = fmul(r, r, p);
      if (e[i]) r = fmul(r, u, p);
    end
    return r;
  endfunction

  function automatic logic [63:0] eff_modulus();
    logic [63:0] p;
    p = fld_p & ((64'd1 << FIELD_BITS) - 1);
    return (p < 3) ? 64'd3 : p;
  endfunction

  function automatic logic [63:0] curve_rhs(logic [63:0] x, logic [63:0] a,
                                            logic [63:0] b, logic [63:0] c,
                                            logic [63:0] p);
    logic [63:0] r;
    r = fadd(x, a, p);
    r = fadd(fmul(r, x, p), b, p);
    return fadd(fmul(r, x, p), c, p);
  endfunction

  function automatic bit lies_on_curve(logic [63:0] x, logic [63:0] y, logic [63:0] a,
                                       logic [63:0] b, logic [63:0] c, logic [63:0] p);
    return fmul(y, y, p) == curve_rhs(x, a, b, c, p);
  endfunction

  // predicted sum of two points under the current shadow configuration
  function automatic pt_sum_t point_sum(pt_pair_t it);
    logic [63:0] p, a, b, c, x1, y1, x2, y2, lam, num, den, nu, x3, y3;
    pt_sum_t s;
    p = eff_modulus();
    a = crv_a % p; b = crv_b % p; c = crv_c % p;
    x1 = it.px1 % p; y1 = it.py1 % p;
    x2 = it.px2 % p; y2 = it.py2 % p;
    s.sum_x = 0; s.sum_y = 1; s.sum_z = 0; s.status = ST_OK;
    if (it.pz1 && !lies_on_curve(x1, y1, a, b, c, p)) begin
      s.status = ST_BAD1;
      n_off_curve++;
      return s;
    end
    if (it.pz2 && !lies_on_curve(x2, y2, a, b, c, p)) begin
      s.status = ST_BAD2;
      n_off_curve++;
      return s;
    end
    if (!it.pz1 && !it.pz2) return s;
    if (!it.pz1) begin
      s.sum_x = x2[31:0]; s.sum_y = y2[31:0]; s.sum_z = 1;
      return s;
    end
    if (!it.pz2) begin
      s.sum_x = x1[31:0]; s.sum_y = y1[31:0]; s.sum_z = 1;
      return s;
    end
    if (x1 == x2) begin
      if (y1 != y2 || y1 == 0) return s;
      n_doublings++;
      num = fmul(fmul(x1, x1, p), 3, p);
      num = fadd(num, fmul(fmul(a, x1, p), 2, p), p);
      num = fadd(num, b, p);
      den = fadd(y1, y1, p);
    end else begin
      n_chords++;
      num = fsub(y2, y1, p);
      den = fsub(x2, x1, p);
    end
    lam = fmul(num, finv(den, p), p);
    nu  = fsub(y1, fmul(lam, x1, p), p);
    x3  = fsub(fsub(fsub(fmul(lam, lam, p), a, p), x1, p), x2, p);
    y3  = fsub(0, fadd(fmul(lam, x3, p), nu, p), p);
    s.sum_x = x3[31:0]; s.sum_y = y3[31:0]; s.sum_z = 1;
    return s;
  endfunction

  // ---------------- point generation ----------------
  // square root by full search is too slow; for p % 4 == 3 use a direct power, else pick x
  // and try y values below 4096 by brute force
  function automatic logic [63:0] fpow(logic [63:0] u, logic [63:0] e, logic [63:0] p);
    logic [63:0] r;
    r = 1 % p;
    for (int i = 63; i >= 0; i--) begin
      r = fmul(r, r, p);
      if (e[i]) r = fmul(r, u, p);
    end
    return r;
  endfunction

  // returns an affine point on the curve, raw coordinates possibly unreduced, or noise if none is found
  function automatic void curve_point(output logic [31:0] x, output logic [31:0] y);
    logic [63:0] p, a, b, c, rx, rhs, r;
    p = eff_modulus();
    a = crv_a % p; b = crv_b % p; c = crv_c % p;
    for (int t = 0; t < 64; t++) begin
      rx = $urandom % p;
      rhs = curve_rhs(rx, a, b, c, p);
      if (p[1:0] == 2'b11) r = fpow(rhs, (p + 1) >> 2, p);
      else begin
        r = 0;
        for (int k = 0; k < p && k < 4096; k++)
          if (fmul(k, k, p) == rhs) begin r = k; break; end
      end
      if (fmul(r, r, p) == rhs) begin
        if ($urandom_range(0, 1)) r = fsub(0, r, p);
        x = rx[31:0];
        y = r[31:0];
        // sometimes hand in an unreduced equivalent
        if ($urandom_range(0, 7) == 0 && {32'd0, x} + p <= 64'hFFFF_FFFF) x = x + p[31:0];
        if ($urandom_range(0, 7) == 0 && {32'd0, y} + p <= 64'hFFFF_FFFF) y = y + p[31:0];
        return;
      end
    end
    // give up on a solution: any point works as noise
    x = $urandom; y = $urandom;
  endfunction

  function automatic pt_pair_t random_pair();
    pt_pair_t it;
    logic [63:0] p;
    int kind;
    p = eff_modulus();
    curve_point(it.px1, it.py1);
    curve_point(it.px2, it.py2);
    it.pz1 = 1; it.pz2 = 1;
    kind = $urandom_range(0, 19);
    case (kind)
      0: it.pz1 = 0;
      1: it.pz2 = 0;
      2: begin it.pz1 = 0; it.pz2 = 0; it.px1 = $urandom; it.py1 = $urandom; end
      3, 4, 5: begin it.px2 = it.px1; it.py2 = it.py1; end   // doubling
      6: begin it.px2 = it.px1; it.py2 = fsub(0, it.py1 % p, p); end   // vertical
      7: it.px1 = $urandom;                                  // likely off curve
      8: it.py2 = $urandom;
      9: begin it.px1 = $urandom; it.py1 = $urandom; it.px2 = $urandom;
         it.py2 = $urandom; it.pz1 = $urandom; it.pz2 = $urandom; end
      default: ;
    endcase
    return it;
  endfunction

  // ---------------- driver ----------------
  int tx_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      tx_gap    <= 0;
    end else if (!in_tvalid || in_tready) begin
      // previous transaction accepted or none offered
      if (in_tvalid) n_sent <= n_sent + 1;
      if (tx_gap > 0) begin
        in_tvalid <= 1'b0;
        tx_gap    <= tx_gap - 1;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        in_tvalid <= 1'b0;
        tx_gap    <= $urandom_range(0, 2);
      end else if (!tx_pause && pending_pairs.size() > 0) begin
        pt_pair_t it;
        it = pending_pairs.pop_front();
        expected_sums.push_back(point_sum(it));
        in_tvalid <= 1'b1;
        in_tdata  <= {6'd0, it.pz2, it.py2, it.px2, it.pz1, it.py1, it.px1};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------- monitor ----------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on result %0d: %s got %h expected %h", n_checked, what, got, want);
    n_errors++;
  endtask

  int rx_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_gap     <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        pt_sum_t got, want;
        got = {out_tdata[31:0], out_tdata[63:32], out_tdata[64], out_tdata[66:65]};
        if (expected_sums.size() == 0) begin
          report_mismatch("unexpected transaction", out_tdata[31:0], 32'd0);
        end else begin
          want = expected_sums.pop_front();
          if (got.sum_x !== want.sum_x) report_mismatch("sum_x", got.sum_x, want.sum_x);
          if (got.sum_y !== want.sum_y) report_mismatch("sum_y", got.sum_y, want.sum_y);
          if (got.sum_z !== want.sum_z)
            report_mismatch("sum_z", 32'(got.sum_z), 32'(want.sum_z));
          if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
        end
        n_checked++;
      end
      if (rx_hold) out_tready <= 1'b0;
      else if (rx_gap > 0) begin
        out_tready <= 1'b0;
        rx_gap     <= rx_gap - 1;
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        rx_gap     <= $urandom_range(0, 2);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------- sequencing ----------------
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_MODULUS: fld_p = val;
      CFG_COEF_A:  crv_a = val;
      CFG_COEF_B:  crv_b = val;
      default:     crv_c = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_pairs.size() > 0 || in_tvalid || expected_sums.size() > 0)
      @(posedge clk);
    // idle gap before touching the configuration
    repeat (20) @(posedge clk);
  endtask

  task automatic set_curve(logic [31:0] p, logic [31:0] a, logic [31:0] b, logic [31:0] c);
    wait_drained();
    write_reg(CFG_MODULUS, p);
    write_reg(CFG_COEF_A, a);
    write_reg(CFG_COEF_B, b);
    write_reg(CFG_COEF_C, c);
  endtask

  task automatic queue_random(int count);
    for (int i = 0; i < count; i++) pending_pairs.push_back(random_pair());
  endtask

  task automatic queue_pair(logic [31:0] x1, logic [31:0] y1, logic z1,
                            logic [31:0] x2, logic [31:0] y2, logic z2);
    pt_pair_t it;
    it = '{px1: x1, py1: y1, pz1: z1, px2: x2, py2: y2, pz2: z2};
    pending_pairs.push_back(it);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    fld_p = 3; crv_a = 0; crv_b = 0; crv_c = 0;
    quiet_tail = 0; rx_hold = 0; tx_pause = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset curve y^2 = x^3 over p = 3: extremes, infinity cases, off-curve
    queue_pair(0, 0, 0, 0, 0, 0);
    queue_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 0, 0);   // unreduced, reduces to (0, 0) on curve
    queue_pair(0, 0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);   // both reduce to (0, 0): doubling with y = 0
    queue_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 0, 1);   // first on, second off: status 2
    queue_pair(0, 0, 1, 0, 0, 1);                           // doubling with y = 0
    queue_pair(1, 1, 1, 1, 1, 1);                           // doubling
    queue_pair(1, 1, 1, 1, 2, 1);                           // vertical line
    queue_pair(1, 1, 1, 2, 2, 1);                           // second off curve: status 2
    queue_pair(4, 7, 1, 0, 0, 0);                           // unreduced, infinity second
    queue_pair(5, 5, 0, 32'hFFFF_FFFD, 32'hFFFF_FFFE, 1);
    wait_drained();

    // modulus below 3 is used as 3
    set_curve(0, 0, 0, 0);
    queue_pair(1, 1, 1, 2, 2, 1);
    queue_pair(2, 1, 1, 2, 1, 1);
    set_curve(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_random(6);

    // largest 32-bit prime, p % 4 == 3 so square roots are direct
    set_curve(32'hFFFF_FFFB, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_random(6);
    // non-prime modulus: inverse defined but meaningless, incl. inverse of 0
    set_curve(32'hFFFF_FFFF, 7, 3, 5);
    queue_random(6);

    // random phases over several curves
    set_curve(32'd1000003, $urandom, $urandom, $urandom);
    queue_random(120);
    set_curve(32'd65519, 0, $urandom, $urandom);
    queue_random(120);
    set_curve(32'd7, $urandom, $urandom, $urandom);
    queue_random(100);

    // long receiver hold-off while the sender keeps offering
    wait_drained();
    rx_hold = 1;
    queue_random(10);
    repeat (30000) @(posedge clk);
    rx_hold = 0;

    // sender pauses until everything has come back
    tx_pause = 1;
    while (expected_sums.size() > 0) @(posedge clk);
    tx_pause = 0;

    set_curve(32'hFFFF_FFC3, $urandom, $urandom, $urandom);   // non-prime (divisible by 5), p % 4 == 3
    queue_random(130);
    set_curve(32'd2147483647, $urandom, 0, $urandom);
    queue_random(130);
    set_curve(32'd251, $urandom, $urandom, 0);
    quiet_tail = 1;
    queue_random(100);

    wait_drained();
    repeat (5000) @(posedge clk);
    $display("covered %0d of %0d sent point additions across eleven curve settings",
             n_checked, n_sent);
    $display("%0d chords, %0d doublings, %0d off-curve inputs predicted",
             n_chords, n_doublings, n_off_curve);
    if (n_errors == 0 && expected_sums.size() == 0) begin
      $display("ec_point_add_prime_field_tb: PASS");
    end else begin
      $display("ec_point_add_prime_field_tb: FAIL");
    end
    $finish;
  end

  // watchdog: ~750 items plus stalls, taken several times over
  initial begin
    #200_000_000;
    $display("timeout");
    $display("ec_point_add_prime_field_tb: FAIL");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/ecpa_pkg.sv
rtl/ecpa_datapath.sv
rtl/ecpa_ctrl.sv
rtl/ec_point_add_prime_field.sv
tb/ec_point_add_prime_field_tb.sv
